/* rtl/tbu_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent package
// Shared types, widths and helpers for the serial tangent-space unit.
// ----------------------------------------------------------------------------
package tbu_pkg;

  // Widths of the internal values.
  localparam int FieldW   = 32;
  localparam int DeltaW   = FieldW + 1;
  localparam int MagW     = 2 * FieldW;
  localparam int TermW    = MagW + 2;
  localparam int TermMagW = MagW + 1;
  localparam int FracBits = 16;

  // Product and term counts of one triangle.
  localparam int NumProds = 14;
  localparam int NumQuots = 6;

  // Saturation limits of a signed Q16.16 result.
  localparam logic [FieldW-1:0] QMax = 32'h7FFF_FFFF;
  localparam logic [FieldW-1:0] QMin = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_t;

  // Difference of two signed 32-bit values, one bit wider.
  function automatic logic signed [DeltaW-1:0] diff33(logic [FieldW-1:0] a,
                                                     logic [FieldW-1:0] b);
    return $signed({a[FieldW-1], a}) - $signed({b[FieldW-1], b});
  endfunction

endpackage

/* rtl/tbu_mul.sv */
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed 33x33 shift-add multiplier that retires one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module tbu_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tbu_pkg::DeltaW-1:0] a,
  input  logic signed [tbu_pkg::DeltaW-1:0] b,
  output logic                              busy,
  output logic                              done,
  output logic signed [tbu_pkg::TermW-1:0]  product
);
  import tbu_pkg::*;

  logic [FieldW-1:0] mcand;
  logic [MagW-1:0]   acc;
  logic              neg;
  logic [4:0]        cnt;
  logic [FieldW:0]   upper;
  logic [DeltaW-1:0] a_mag;
  logic [DeltaW-1:0] b_mag;

  // Operand magnitudes; each fits 32 bits.
  assign a_mag = a[DeltaW-1] ? DeltaW'(-a) : DeltaW'(a);
  assign b_mag = b[DeltaW-1] ? DeltaW'(-b) : DeltaW'(b);

  // Add the multiplicand into the high half when the low bit is set.
  assign upper = {1'b0, acc[MagW-1:FieldW]} + (acc[0] ? {1'b0, mcand} : '0);

  // Control and shift registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a_mag[FieldW-1:0];
      acc   <= {{FieldW{1'b0}}, b_mag[FieldW-1:0]};
      neg   <= a[DeltaW-1] ^ b[DeltaW-1];
    end else if (busy) begin
      acc <= {upper, acc[FieldW-1:1]};
    end
  end

  // Signed product, two bits wider than the magnitude.
  assign product = neg ? -$signed({2'b00, acc}) : $signed({2'b00, acc});

endmodule

/* rtl/tbu_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider giving one quotient bit a cycle for (num * 2^16) / den,
// truncated toward zero and saturated to signed Q16.16.
// ----------------------------------------------------------------------------
module tbu_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tbu_pkg::TermW-1:0]    num,
  input  logic        [tbu_pkg::TermMagW-1:0] den_mag,
  input  logic                                den_neg,
  output logic                                busy,
  output logic                                done,
  output logic        [tbu_pkg::FieldW-1:0]   quot
);
  import tbu_pkg::*;

  logic [TermW-1:0]    num_abs;
  logic [TermMagW-1:0] nmag;
  logic [TermMagW-1:0] den;
  logic [TermW-1:0]    rem;
  logic [TermW-1:0]    rem_shift;
  logic [FieldW-1:0]   low;
  logic [FieldW-1:0]   q;
  logic [FieldW-1:0]   limit;
  logic [FieldW-1:0]   q_sat;
  logic                neg;
  logic                big;
  logic                ge;
  logic [4:0]          cnt;

  assign num_abs = num[TermW-1] ? TermW'(-num) : TermW'(num);
  assign nmag    = num_abs[TermMagW-1:0];

  // One restoring step.
  assign rem_shift = {rem[TermW-2:0], low[FieldW-1]};
  assign ge        = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A quotient of 2^32 or more is flagged up front and saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      den <= den_mag;
      neg <= num[TermW-1] ^ den_neg;
      big <= {{FracBits{1'b0}}, nmag} >= {den_mag, {FracBits{1'b0}}};
      rem <= {{(TermW-TermMagW+FracBits){1'b0}}, nmag[TermMagW-1:FracBits]};
      low <= {nmag[FracBits-1:0], {(FieldW-FracBits){1'b0}}};
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? rem_shift - {1'b0, den} : rem_shift;
      low <= {low[FieldW-2:0], 1'b0};
      q   <= {q[FieldW-2:0], ge};
    end
  end

  // Saturate and apply the sign.
  assign limit = neg ? QMin : QMax;
  assign q_sat = (big || (q > limit)) ? limit : q;
  assign quot  = neg ? (~q_sat + 32'd1) : q_sat;

endmodule

/* rtl/triangle_tangent_bitangent_unit.sv */
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent unit
// Per-triangle tangent-space basis from three vertices, computed serially.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one vertex per request (position and
// texture coordinate, signed Q16.16). Vertices group in threes. The first
// two are stored and accepted while the unit is idle. The third starts the
// computation: fourteen products through a serial shift-add multiplier,
// then six quotients through a serial restoring divider; no vertex is
// accepted until the triangle is done. A zero texture determinant skips
// the divider, giving zero vectors with degenerate set.
// The output channel carries one request per triangle and holds it in the
// output registers until taken. While the receiver stalls, the first two
// vertices of the next triangle are still accepted; the third waits.
// Reset clears the vertex count and all handshake state.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tbu_pkg::FieldW-1:0]  pos_x,
  input  logic [tbu_pkg::FieldW-1:0]  pos_y,
  input  logic [tbu_pkg::FieldW-1:0]  pos_z,
  input  logic [tbu_pkg::FieldW-1:0]  tex_u,
  input  logic [tbu_pkg::FieldW-1:0]  tex_v,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tbu_pkg::FieldW-1:0]  tangent_x,
  output logic [tbu_pkg::FieldW-1:0]  tangent_y,
  output logic [tbu_pkg::FieldW-1:0]  tangent_z,
  output logic [tbu_pkg::FieldW-1:0]  bitangent_x,
  output logic [tbu_pkg::FieldW-1:0]  bitangent_y,
  output logic [tbu_pkg::FieldW-1:0]  bitangent_z,
  output logic                        degenerate
);
  import tbu_pkg::*;

  state_t state, state_next;

  logic [1:0]  vertex_count;
  logic [FieldW-1:0] v0 [5];
  logic [FieldW-1:0] v1 [5];
  logic signed [DeltaW-1:0] e1 [3];
  logic signed [DeltaW-1:0] e2 [3];
  logic signed [DeltaW-1:0] du1, dv1, du2, dv2;
  logic [FieldW-1:0] vin [5];

  logic [3:0]  pidx;
  logic [2:0]  qidx;
  logic signed [TermW-1:0] acc;
  logic signed [TermW-1:0] acc_next;
  logic signed [TermW-1:0] num_q [NumQuots];
  logic [TermMagW-1:0] det_mag;
  logic [TermW-1:0]    det_abs;
  logic                det_neg;
  logic                det_zero;
  logic [FieldW-1:0]   res [NumQuots];

  logic in_fire, tri_fire, out_fire;
  logic mul_start, mul_busy, mul_done;
  logic div_start, div_busy, div_done;
  logic signed [DeltaW-1:0] op_a, op_b;
  logic signed [TermW-1:0]  product;
  logic [FieldW-1:0]        quot;

  assign vin[0] = pos_x;
  assign vin[1] = pos_y;
  assign vin[2] = pos_z;
  assign vin[3] = tex_u;
  assign vin[4] = tex_v;

  // Handshake.
  assign in_stall = (state != ST_IDLE) || ((vertex_count == 2'd2) && out_valid);
  assign in_fire  = in_valid && !in_stall;
  assign tri_fire = in_fire && (vertex_count == 2'd2);
  assign out_fire = out_valid && !out_stall;
  assign det_zero = (det_mag == '0);

  // Operand pair of each product; odd products are subtracted.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (pidx)
      4'd0:  begin op_a = du1; op_b = dv2;   end
      4'd1:  begin op_a = du2; op_b = dv1;   end
      4'd2:  begin op_a = dv2; op_b = e1[0]; end
      4'd3:  begin op_a = dv1; op_b = e2[0]; end
      4'd4:  begin op_a = dv2; op_b = e1[1]; end
      4'd5:  begin op_a = dv1; op_b = e2[1]; end
      4'd6:  begin op_a = dv2; op_b = e1[2]; end
      4'd7:  begin op_a = dv1; op_b = e2[2]; end
      4'd8:  begin op_a = du1; op_b = e2[0]; end
      4'd9:  begin op_a = du2; op_b = e1[0]; end
      4'd10: begin op_a = du1; op_b = e2[1]; end
      4'd11: begin op_a = du2; op_b = e1[1]; end
      4'd12: begin op_a = du1; op_b = e2[2]; end
      4'd13: begin op_a = du2; op_b = e1[2]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign acc_next = pidx[0] ? (acc - product) : product;
  assign det_abs  = acc_next[TermW-1] ? TermW'(-acc_next) : TermW'(acc_next);

  tbu_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (op_a),
    .b       (op_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (product)
  );

  tbu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (num_q[0]),
    .den_mag (det_mag),
    .den_neg (det_neg),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (quot)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (tri_fire) state_next = ST_MUL;
      ST_MUL: begin
        if (mul_done && (pidx == 4'(NumProds - 1))) begin
          state_next = det_zero ? ST_IDLE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && (qidx == 3'(NumQuots - 1))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Unit issue.
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_MUL:  mul_start = !mul_busy && !mul_done;
      ST_DIV:  div_start = !div_busy && !div_done;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= '0;
      pidx         <= '0;
      qidx         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) vertex_count <= tri_fire ? 2'd0 : vertex_count + 2'd1;
      if (tri_fire) begin
        pidx <= '0;
        qidx <= '0;
      end
      if ((state == ST_MUL) && mul_done) pidx <= pidx + 4'd1;
      if ((state == ST_DIV) && div_done) qidx <= qidx + 3'd1;
      if (out_fire) out_valid <= 1'b0;
      if ((state == ST_MUL) && mul_done && (pidx == 4'(NumProds - 1)) && det_zero) begin
        out_valid <= 1'b1;
      end
      if ((state == ST_DIV) && div_done && (qidx == 3'(NumQuots - 1))) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Vertex store and edge deltas.
  always_ff @(posedge clk) begin
    if (in_fire && (vertex_count == 2'd0)) begin
      for (int i = 0; i < 5; i++) v0[i] <= vin[i];
    end
    if (in_fire && (vertex_count == 2'd1)) begin
      for (int i = 0; i < 5; i++) v1[i] <= vin[i];
    end
    if (tri_fire) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= diff33(v1[i], v0[i]);
        e2[i] <= diff33(vin[i], v0[i]);
      end
      du1 <= diff33(v1[3], v0[3]);
      dv1 <= diff33(v1[4], v0[4]);
      du2 <= diff33(tex_u, v0[3]);
      dv2 <= diff33(tex_v, v0[4]);
    end
  end

  // Term accumulation: the determinant is kept, numerators shift in.
  always_ff @(posedge clk) begin
    if ((state == ST_MUL) && mul_done) begin
      acc <= acc_next;
      if (pidx[0]) begin
        if (pidx[3:1] == 3'd0) begin
          det_neg <= acc_next[TermW-1];
          det_mag <= det_abs[TermMagW-1:0];
        end else begin
          for (int j = 0; j < NumQuots - 1; j++) num_q[j] <= num_q[j+1];
          num_q[NumQuots-1] <= acc_next;
        end
      end
    end else if ((state == ST_DIV) && div_done) begin
      for (int j = 0; j < NumQuots - 1; j++) num_q[j] <= num_q[j+1];
      num_q[NumQuots-1] <= num_q[0];
    end
  end

  // Result registers, filled in output order.
  always_ff @(posedge clk) begin
    if ((state == ST_MUL) && mul_done && (pidx == 4'(NumProds - 1)) && det_zero) begin
      for (int j = 0; j < NumQuots; j++) res[j] <= '0;
      degenerate <= 1'b1;
    end else if ((state == ST_DIV) && div_done) begin
      for (int j = 0; j < NumQuots - 1; j++) res[j] <= res[j+1];
      res[NumQuots-1] <= quot;
      degenerate      <= 1'b0;
    end
  end

  assign tangent_x   = res[0];
  assign tangent_y   = res[1];
  assign tangent_z   = res[2];
  assign bitangent_x = res[3];
  assign bitangent_y = res[4];
  assign bitangent_z = res[5];

  // The multiplier only runs while products are being formed.
  a_mul_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> state == ST_MUL) else $error("multiplier busy outside product phase");

  // The divider only runs while quotients are being formed.
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV) else $error("divider busy outside quotient phase");

  // A third vertex always starts the product phase.
  a_tri_starts: assert property (@(posedge clk) disable iff (rst)
    tri_fire |=> state == ST_MUL) else $error("third vertex did not start products");

  // Division never runs with a zero determinant.
  a_det_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !det_zero) else $error("division with zero determinant");

  // No result is pending while quotients are written.
  a_div_no_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !out_valid) else $error("result overwritten while pending");

endmodule

/* tb/sv/tb_triangle_tangent_bitangent_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent unit testbench
// Feeds vertices in threes, predicts each triangle's tangent, bitangent and
// degenerate flag with exact wide arithmetic, and checks every request that
// leaves the unit. Both sides idle at random, and the receiver once holds off
// long enough to back the unit up into its input.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_bitangent_unit;
  import tbu_pkg::*;

  typedef struct {
    logic signed [FieldW-1:0] px, py, pz, tu, tv;
  } vertex_t;

  typedef struct {
    logic [FieldW-1:0] tan [3];
    logic [FieldW-1:0] bit_v [3];
    logic              degen;
  } basis_t;

  typedef struct {
    vertex_t vtx;
    bit      typed;
    basis_t  want;
  } row_t;

  localparam int NumRandTris = 133;
  localparam int LongHold    = 3000;

  logic              clk, rst;
  logic              in_valid, in_stall, out_valid, out_stall;
  logic [FieldW-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic [FieldW-1:0] tangent_x, tangent_y, tangent_z;
  logic [FieldW-1:0] bitangent_x, bitangent_y, bitangent_z;
  logic              degenerate;

  basis_t  basis_queue[$];
  vertex_t held[2];
  int      held_count;
  int      fail_count;
  int      results_seen;
  bit      no_idle_in;
  row_t    rows[$];

  triangle_tangent_bitangent_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // One coordinate of a vertex, sign-extended to the working width.
  function automatic logic signed [127:0] coord(vertex_t v, int idx);
    case (idx)
      0: return v.px;
      1: return v.py;
      2: return v.pz;
      3: return v.tu;
      default: return v.tv;
    endcase
  endfunction

  // Quotient (num * 2^16) / den, truncated toward zero and saturated.
  function automatic logic [FieldW-1:0] q16_quotient(logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FracBits) / den;
    if (q > 128'sh7FFF_FFFF) return QMax;
    if (q < -128'sh8000_0000) return QMin;
    return q[FieldW-1:0];
  endfunction

  // Tangent-space basis of one triangle.
  function automatic basis_t triangle_basis(vertex_t a, vertex_t b, vertex_t c);
    logic signed [127:0] e1[3], e2[3];
    logic signed [127:0] du1, dv1, du2, dv2, det;
    basis_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = coord(b, i) - coord(a, i);
      e2[i] = coord(c, i) - coord(a, i);
    end
    du1 = coord(b, 3) - coord(a, 3);
    dv1 = coord(b, 4) - coord(a, 4);
    du2 = coord(c, 3) - coord(a, 3);
    dv2 = coord(c, 4) - coord(a, 4);
    det = du1 * dv2 - du2 * dv1;
    r.degen = (det == 0);
    for (int i = 0; i < 3; i++) begin
      if (r.degen) begin
        r.tan[i]   = '0;
        r.bit_v[i] = '0;
      end else begin
        r.tan[i]   = q16_quotient(dv2 * e1[i] - dv1 * e2[i], det);
        r.bit_v[i] = q16_quotient(du1 * e2[i] - du2 * e1[i], det);
      end
    end
    return r;
  endfunction

  function automatic vertex_t vtx(int x, int y, int z, int u, int v);
    vertex_t r;
    r.px = x; r.py = y; r.pz = z; r.tu = u; r.tv = v;
    return r;
  endfunction

  function automatic basis_t basis_of(int tx, int ty, int tz, int bx, int by, int bz,
                                      bit dg);
    basis_t r;
    r.tan[0] = tx; r.tan[1] = ty; r.tan[2] = tz;
    r.bit_v[0] = bx; r.bit_v[1] = by; r.bit_v[2] = bz;
    r.degen = dg;
    return r;
  endfunction

  task automatic add_row(vertex_t v, bit typed = 0, basis_t want = '{default: '0});
    row_t r;
    r.vtx = v;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endtask

  // Random coordinate: mostly small magnitudes, sometimes any 32-bit value.
  function automatic int rand_coord(bit full);
    if (full) return $urandom;
    return int'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
  endfunction

  // Track the vertex count and queue the expected basis on a third vertex.
  task automatic note_vertex(vertex_t v, bit typed, basis_t want);
    if (held_count < 2) begin
      held[held_count] = v;
      held_count++;
    end else begin
      held_count = 0;
      basis_queue.insert(basis_queue.size(),
                         typed ? want : triangle_basis(held[0], held[1], v));
    end
  endtask

  // Offer one vertex request and wait until it is taken.
  task automatic send_vertex(row_t r);
    int gap;
    gap = no_idle_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= r.vtx.px; pos_y <= r.vtx.py; pos_z <= r.vtx.pz;
    tex_u <= r.vtx.tu; tex_v <= r.vtx.tv;
    do @(posedge clk); while (in_stall);
    note_vertex(r.vtx, r.typed, r.want);
  endtask

  // Receiver stall: a random hold-off per request, and one long stretch.
  initial begin
    int hold;
    bit long_done;
    long_done = 0;
    hold = 0;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (!long_done && results_seen == 5) begin
          hold = LongHold;
          long_done = 1;
        end else if (results_seen % 40 < 10) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, 16);
        end
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    basis_t exp_b;
    logic [FieldW-1:0] got [6];
    logic [FieldW-1:0] want [6];
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (basis_queue.size() == 0) begin
        $display("%0t: unexpected result request", $time);
        fail_count++;
      end else begin
        exp_b = basis_queue.pop_front();
        got = '{tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z};
        want = '{exp_b.tan[0], exp_b.tan[1], exp_b.tan[2],
                 exp_b.bit_v[0], exp_b.bit_v[1], exp_b.bit_v[2]};
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: vector field %0d expected %h actual %h", $time, i, want[i],
                     got[i]);
            fail_count++;
          end
        end
        if (degenerate !== exp_b.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_b.degen,
                   degenerate);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t r;
    int mode;
    int waited;
    vertex_t t[3];
    fail_count = 0;
    results_seen = 0;
    held_count = 0;
    no_idle_in = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0; tex_u = '0; tex_v = '0;

    // All-zero triangle: degenerate.
    repeat (3) add_row(vtx(0, 0, 0, 0, 0));
    rows[2].typed = 1;
    rows[2].want = basis_of(0, 0, 0, 0, 0, 0, 1);
    // Unit texture basis: tangent equals the first edge, bitangent the second.
    add_row(vtx(0, 0, 0, 0, 0));
    add_row(vtx(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h10000, 0));
    add_row(vtx(32'h1234_5678, 32'hFFFF_FFFF, 0, 0, 32'h10000), 1,
            basis_of(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h1234_5678, 32'hFFFF_FFFF, 0,
                     0));
    // Tiny determinant: positive and negative saturation.
    add_row(vtx(0, 0, 0, 0, 0));
    add_row(vtx(32'h10000, -32'h10000, 0, 1, 0));
    add_row(vtx(0, 0, 0, 0, 1), 1,
            basis_of(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
    // Extreme positions and texture coordinates.
    add_row(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000));
    add_row(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF));
    add_row(vtx(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    // Collinear texture coordinates: degenerate with nonzero edges.
    add_row(vtx(5, 6, 7, 0, 0));
    add_row(vtx(32'h30000, -9, 4, 1, 1));
    add_row(vtx(-32'h20000, 11, 32'h7FFF_0000, 2, 2), 1,
            basis_of(0, 0, 0, 0, 0, 0, 1));
    // Inexact quotients of both signs, truncated toward zero.
    add_row(vtx(0, 0, 0, 0, 0));
    add_row(vtx(1, -1, 32'h10000, 3, 0));
    add_row(vtx(-1, 1, 32'h7, 0, 7));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_vertex(rows[i]);

    // Random triangles.
    for (int n = 0; n < NumRandTris; n++) begin
      no_idle_in = (n % 30) < 6;
      mode = $urandom_range(0, 99);
      for (int k = 0; k < 3; k++)
        t[k] = vtx(rand_coord(mode >= 75), rand_coord(mode >= 75), rand_coord(mode >= 75),
                   rand_coord(mode >= 75 || mode < 10), rand_coord(mode >= 75));
      if (mode >= 90) t[2].tu = t[0].tu;
      if (mode >= 90) t[2].tv = t[0].tv;
      if (mode >= 95) begin
        t[1].tu = t[0].tu + 2 * (t[2].tu - t[0].tu);
        t[1].tv = t[0].tv + 2 * (t[2].tv - t[0].tv);
        t[2] = vtx(rand_coord(1), rand_coord(1), rand_coord(1), $urandom, $urandom);
      end
      for (int k = 0; k < 3; k++) begin
        r.vtx = t[k];
        r.typed = 0;
        send_vertex(r);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (basis_queue.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (800) @(posedge clk);
    if (basis_queue.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, basis_queue.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tbu_pkg.sv
rtl/tbu_mul.sv
rtl/tbu_div.sv
rtl/triangle_tangent_bitangent_unit.sv
tb/sv/tb_triangle_tangent_bitangent_unit.sv
